/* sv/cmmv_pkg.sv */
// package for the channel mix matrix-vector block
// field widths, action and register index codes, controller/datapath structs
// no dependencies
`default_nettype none

package cmmv_pkg;

  localparam int SLOT_W      = 6;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 38;
  localparam int DEST_W      = 8;
  localparam int SRC_COUNT_W = 7;
  localparam int DST_COUNT_W = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_COEF = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_COUNT   = 1'b1;

  typedef struct packed {
    logic capture;
    logic mem_we;
    logic rd_en;
    logic mul_en;
    logic acc_en;
  } cmmv_cmd_t;

  typedef struct packed {
    logic row_end;
  } cmmv_sts_t;

endpackage

`default_nettype wire

/* sv/cmmv_ifs.sv */
// valid/ready channel interfaces for the channel mix block
// depends on cmmv_pkg for field widths
`default_nettype none

interface cmmv_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic [cmmv_pkg::SLOT_W-1:0]           source_slot;
  logic signed [cmmv_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, action, source_slot, sample, input ready);
  modport sink (input valid, action, source_slot, sample, output ready);
endinterface

interface cmmv_out_if;
  logic                               valid;
  logic                               ready;
  logic [cmmv_pkg::DEST_W-1:0]        dest_channel;
  logic signed [cmmv_pkg::SUM_W-1:0]  mixed_level;
  logic                               final_channel;

  modport source (output valid, dest_channel, mixed_level, final_channel, input ready);
  modport sink (input valid, dest_channel, mixed_level, final_channel, output ready);
endinterface

`default_nettype wire

/* sv/channel_mix_matrix_vector.sv */
// channel_mix_matrix_vector: matrix-vector mixer of source levels into destinations
// input beats carry a source load (action 0) or the next row-major coefficient (action 1)
// one result beat per completed row: destination index, full-width sum, last flag
// cfg_we/cfg_index/cfg_data write source_count (index 0) and dest_count (index 1)
// a load beat writes the store, and in_ch.ready stays high
// a coefficient beat runs as store read, then 16x16 multiply, then 38-bit accumulate
// the sequence runs through one multiplier and one accumulator, one coefficient at a time
// the row's last accumulate loads the output register and raises out_ch.valid with it
// the next beat is taken while a result waits; if the row after ends before out_ch.ready,
// the accumulate step holds and in_ch.ready stays low until the result is taken
// reset (rst_n low, synchronous) clears counters and sum, sets both counts to 1
// source store contents are not cleared; slots must be loaded before use
// depends on cmmv_pkg, cmmv_ifs, cmmv_ctrl and cmmv_dp
`default_nettype none

module channel_mix_matrix_vector #(
  parameter int MAX_SOURCES = 64,
  parameter int MAX_DESTS   = 256
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  cmmv_in_if.sink                             in_ch,
  cmmv_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire  [cmmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [cmmv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cmmv_pkg::*;

  cmmv_cmd_t cmd;
  cmmv_sts_t sts;

  cmmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmmv_dp #(
    .MAX_SOURCES (MAX_SOURCES),
    .MAX_DESTS   (MAX_DESTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_slot   (in_ch.source_slot),
    .in_sample (in_ch.sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_dest  (out_ch.dest_channel),
    .out_level (out_ch.mixed_level),
    .out_final (out_ch.final_channel)
  );

endmodule

`default_nettype wire

/* sv/cmmv_dp.sv */
// datapath: count registers, source store, multiplier, accumulator, result register
// depends on cmmv_pkg; driven by cmmv_ctrl commands
`default_nettype none

module cmmv_dp #(
  parameter int MAX_SOURCES = 64,
  parameter int MAX_DESTS   = 256
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire  cmmv_pkg::cmmv_cmd_t                cmd,
  output cmmv_pkg::cmmv_sts_t                      sts,
  input  wire  [cmmv_pkg::SLOT_W-1:0]              in_slot,
  input  wire  signed [cmmv_pkg::SAMPLE_W-1:0]     in_sample,
  input  wire                                      cfg_we,
  input  wire  [cmmv_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [cmmv_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic [cmmv_pkg::DEST_W-1:0]              out_dest,
  output logic signed [cmmv_pkg::SUM_W-1:0]        out_level,
  output logic                                     out_final
);
  import cmmv_pkg::*;

  localparam int COL_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int ADDR_W = (COL_W > SLOT_W) ? COL_W : SLOT_W;
  localparam int SRC_CW = ($clog2(MAX_SOURCES + 1) > SRC_COUNT_W) ?
                          $clog2(MAX_SOURCES + 1) : SRC_COUNT_W;
  localparam int DST_CW = ($clog2(MAX_DESTS + 1) > DST_COUNT_W) ?
                          $clog2(MAX_DESTS + 1) : DST_COUNT_W;

  logic [SRC_COUNT_W-1:0]     src_count_r;
  logic [DST_COUNT_W-1:0]     dst_count_r;
  logic [COL_W-1:0]           col_r;
  logic [DEST_W-1:0]          row_r;
  logic [SUM_W-1:0]           sum_r;
  logic signed [SAMPLE_W-1:0] coef_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [SAMPLE_W-1:0]        store [MAX_SOURCES];

  logic [ADDR_W-1:0] slot_ext;
  logic              slot_ok;
  logic [SRC_CW-1:0] src_ext;
  logic [SRC_CW-1:0] scount_eff;
  logic [SRC_CW-1:0] col_next;
  logic [DST_CW-1:0] dst_ext;
  logic [DST_CW-1:0] dcount_eff;
  logic [DST_CW-1:0] row_next;
  logic              last_row;
  logic [SUM_W-1:0]  sum_add;

  // clamp of the count registers
  always_comb begin
    src_ext = SRC_CW'(src_count_r);
    if (src_ext == '0) begin
      scount_eff = SRC_CW'(1);
    end else if (src_ext > SRC_CW'(MAX_SOURCES)) begin
      scount_eff = SRC_CW'(MAX_SOURCES);
    end else begin
      scount_eff = src_ext;
    end
    dst_ext = DST_CW'(dst_count_r);
    if (dst_ext == '0) begin
      dcount_eff = DST_CW'(1);
    end else if (dst_ext > DST_CW'(MAX_DESTS)) begin
      dcount_eff = DST_CW'(MAX_DESTS);
    end else begin
      dcount_eff = dst_ext;
    end
  end

  assign col_next    = SRC_CW'(col_r) + SRC_CW'(1);
  assign row_next    = DST_CW'(row_r) + DST_CW'(1);
  assign sts.row_end = (col_next >= scount_eff);
  assign last_row    = (row_next >= dcount_eff);
  assign sum_add     = sum_r + {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign slot_ext = ADDR_W'(in_slot);
  assign slot_ok  = ({1'b0, slot_ext} < (ADDR_W + 1)'(MAX_SOURCES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_count_r <= SRC_COUNT_W'(1);
      dst_count_r <= DST_COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_COUNT: src_count_r <= cfg_data[SRC_COUNT_W-1:0];
        CFG_DEST_COUNT:   dst_count_r <= cfg_data[DST_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // source store
  always_ff @(posedge clk) begin
    if (cmd.mem_we && slot_ok) begin
      store[slot_ext[COL_W-1:0]] <= in_sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      coef_r <= in_sample;
    end
    if (cmd.mul_en) begin
      prod_r <= rd_data_r * coef_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sum_r <= '0;
    end else if (cmd.acc_en) begin
      if (sts.row_end) begin
        col_r <= '0;
        sum_r <= '0;
        row_r <= last_row ? '0 : row_r + DEST_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
        sum_r <= sum_add;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.acc_en && sts.row_end) begin
      out_dest  <= row_r;
      out_level <= $signed(sum_add);
      out_final <= last_row;
    end
  end

endmodule

`default_nettype wire

/* sv/cmmv_ctrl.sv */
// controller: accepts beats, sequences read, multiply and accumulate, owns out valid
// depends on cmmv_pkg; drives cmmv_dp
`default_nettype none

module cmmv_ctrl (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire                        in_action,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire                        out_ready,
  input  wire  cmmv_pkg::cmmv_sts_t  sts,
  output cmmv_pkg::cmmv_cmd_t        cmd
);
  import cmmv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_COEF) begin
            cmd.capture = 1'b1;
            cmd.rd_en   = 1'b1;
            state_nxt   = S_MUL;
          end else begin
            cmd.mem_we = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        if (!sts.row_end || out_free) begin
          cmd.acc_en = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.row_end) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r == (state_r == S_IDLE))
    else $error("in_ready out of step with state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en && sts.row_end |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

  a_mul_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |=> state_r == S_ACC)
    else $error("multiply not followed by accumulate");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_we |-> state_r == S_IDLE && !cmd.acc_en)
    else $error("store write outside idle");
`endif

endmodule

`default_nettype wire

/* tb/channel_mix_matrix_vector_test.sv */
// testbench for channel_mix_matrix_vector: directed and random load/coefficient beats
// a scoreboard mixer predicts each row result; register settings change between phases
// depends on cmmv_pkg, cmmv_ifs and the channel_mix_matrix_vector rtl
`default_nettype none

module channel_mix_matrix_vector_test;
  import cmmv_pkg::*;

  localparam int NSRC = 64;
  localparam int NDST = 256;
  localparam logic signed [SAMPLE_W-1:0] LVL_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] LVL_MAX = 16'sh7FFF;

  typedef struct {
    logic                       action;
    logic [SLOT_W-1:0]          slot;
    logic signed [SAMPLE_W-1:0] sample;
  } mix_beat_t;

  typedef struct {
    logic [DEST_W-1:0]       dest;
    logic signed [SUM_W-1:0] level;
    logic                    last_dest;
  } mix_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cmmv_in_if  in_ch();
  cmmv_out_if out_ch();

  channel_mix_matrix_vector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // register copies for the scoreboard mixer; the beat generator also reads the source count
  logic [SRC_COUNT_W-1:0] src_reg = 7'd1;
  logic [DST_COUNT_W-1:0] dst_reg = 9'd1;

  // scoreboard mixer state
  logic signed [SAMPLE_W-1:0] source_levels [NSRC];
  logic [SUM_W-1:0] row_sum = '0;
  int unsigned mix_col = 0;
  int unsigned mix_row = 0;
  mix_result_t pending_mixes[$];

  // beat generator state
  mix_beat_t queued_beats[$];
  logic [NSRC-1:0] slot_loaded = '0;
  int unsigned gen_col = 0;

  int beats_queued = 0;
  int beats_taken = 0;
  int loads_taken = 0;
  int mixes_seen = 0;
  int last_rows = 0;
  int mix_errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int unsigned eff_count(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic void mix_predict(mix_beat_t b);
    int unsigned scount;
    int unsigned dcount;
    logic signed [PROD_W-1:0] prod;
    mix_result_t r;
    scount = eff_count(32'(src_reg), NSRC);
    dcount = eff_count(32'(dst_reg), NDST);
    if (b.action == ACT_LOAD) begin
      source_levels[b.slot] = b.sample;
      return;
    end
    prod = source_levels[mix_col] * b.sample;
    row_sum = row_sum + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    if (mix_col + 1 < scount) begin
      mix_col++;
      return;
    end
    r.dest = mix_row[DEST_W-1:0];
    r.level = row_sum;
    r.last_dest = (mix_row + 1 >= dcount);
    pending_mixes.push_back(r);
    row_sum = '0;
    mix_col = 0;
    mix_row = r.last_dest ? 0 : ((mix_row + 1) & 8'hFF);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(19))
      0: return LVL_MIN;
      1: return LVL_MAX;
      2: return '0;
      3: return -16'sd1;
      default: return SAMPLE_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void queue_beat(logic act, logic [SLOT_W-1:0] slot,
                                     logic signed [SAMPLE_W-1:0] v);
    mix_beat_t b;
    b.action = act;
    b.slot = slot;
    b.sample = v;
    queued_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic void push_load(int unsigned slot, logic signed [SAMPLE_W-1:0] v);
    slot_loaded[slot] = 1'b1;
    queue_beat(ACT_LOAD, slot[SLOT_W-1:0], v);
  endfunction

  // a coefficient only reads a slot that has been loaded
  function automatic void push_coef(logic signed [SAMPLE_W-1:0] v);
    if (!slot_loaded[gen_col]) push_load(gen_col, pick_level());
    queue_beat(ACT_COEF, SLOT_W'($urandom_range(NSRC-1)), v);
    if (gen_col + 1 < eff_count(32'(src_reg), NSRC)) gen_col++;
    else gen_col = 0;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOURCE_COUNT) src_reg = val[SRC_COUNT_W-1:0];
    else dst_reg = val[DST_COUNT_W-1:0];
  endtask

  task automatic settle();
    do @(negedge clk);
    while (beats_taken != beats_queued || pending_mixes.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  // driver
  always @(posedge clk) begin : drive
    mix_beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (queued_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = queued_beats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= nxt.action;
        in_ch.source_slot <= nxt.slot;
        in_ch.sample <= nxt.sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : accept
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    mix_beat_t got;
    mix_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        got.action = in_ch.action;
        got.slot = in_ch.source_slot;
        got.sample = in_ch.sample;
        beats_taken++;
        if (got.action == ACT_LOAD) loads_taken++;
        mix_predict(got);
      end
      if (out_ch.valid && out_ch.ready) begin
        mixes_seen++;
        if (out_ch.final_channel) last_rows++;
        if (pending_mixes.size() == 0) begin
          mix_errors++;
          if (mix_errors <= 10)
            $display("unexpected result beat: dest %0d level %0d last %0b",
                     out_ch.dest_channel, out_ch.mixed_level, out_ch.final_channel);
        end else begin
          want = pending_mixes.pop_front();
          if (out_ch.dest_channel !== want.dest || out_ch.mixed_level !== want.level ||
              out_ch.final_channel !== want.last_dest) begin
            mix_errors++;
            if (mix_errors <= 10)
              $display({"mismatch: expected dest %0d level %0d last %0b, ",
                        "got dest %0d level %0d last %0b"},
                       want.dest, want.level, want.last_dest, out_ch.dest_channel,
                       out_ch.mixed_level, out_ch.final_channel);
          end
        end
      end
    end
  end

  initial begin
    #(20 * 400000);
    $display("timeout with %0d results still expected", pending_mixes.size());
    $display("channel_mix_matrix_vector_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned plan_src[8] = '{64, 0, 127, 5, 2, 1, 8, 33};
    int unsigned plan_dst[8] = '{2, 511, 3, 4, 256, 7, 1, 9};
    int unsigned plan_n[8]   = '{220, 360, 230, 150, 150, 130, 130, 130};
    int unsigned sc;
    int unsigned dc;
    int unsigned slot;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.source_slot = '0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset counts: every coefficient closes a one-row matrix
    set_idling(0);
    push_load(0, LVL_MIN);
    push_coef(LVL_MIN);
    push_coef(LVL_MAX);
    push_load(63, LVL_MAX);
    push_load(0, LVL_MAX);
    push_coef(LVL_MIN);
    push_coef('0);
    push_load(0, -16'sd1);
    push_coef(-16'sd1);
    settle();

    // three sources, two rows, with a load landing mid-row
    write_reg(CFG_SOURCE_COUNT, 3);
    write_reg(CFG_DEST_COUNT, 2);
    push_load(1, LVL_MAX);
    push_load(2, LVL_MIN);
    push_coef(LVL_MAX);
    push_coef(LVL_MIN);
    push_load(2, 16'sd12345);
    push_coef(LVL_MIN);
    push_coef(16'sd1);
    push_coef(16'sd1);
    settle();

    // shrink the row while one is open, then the matrix while a row is pending
    write_reg(CFG_SOURCE_COUNT, 2);
    push_coef(16'sd7);
    push_coef(LVL_MAX);
    push_coef(LVL_MAX);
    settle();
    write_reg(CFG_DEST_COUNT, 1);
    push_coef(-16'sd3);
    push_coef(16'sd5);
    settle();

    for (int p = 0; p < 8; p++) begin
      sc = plan_src[p];
      dc = plan_dst[p];
      if (p >= 6) begin
        sc = $urandom_range(1, 12);
        dc = $urandom_range(1, 20);
      end
      write_reg(CFG_SOURCE_COUNT, sc);
      write_reg(CFG_DEST_COUNT, dc);
      set_idling(p % 4);
      repeat (plan_n[p]) begin
        if ($urandom_range(99) < 20) begin
          if ($urandom_range(1)) slot = $urandom_range(NSRC - 1);
          else slot = $urandom_range(eff_count(32'(src_reg), NSRC) - 1);
          push_load(slot, pick_level());
        end else begin
          push_coef(pick_level());
        end
      end
      settle();
    end

    $display("ran %0d input beats (%0d loads, %0d coefficients) over several row/matrix sizes",
             beats_taken, loads_taken, beats_taken - loads_taken);
    $display("checked %0d row results, %0d of them closing a matrix", mixes_seen, last_rows);
    if (mix_errors == 0) begin
      $display("channel_mix_matrix_vector_test: PASS");
    end else begin
      $display("%0d result errors", mix_errors);
      $display("channel_mix_matrix_vector_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
